### src/text_to_page_description_tokenizer_assert.svh
// Assertion macros shared by the tokenizer modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef TEXT_TO_PAGE_DESCRIPTION_TOKENIZER_ASSERT_SVH
`define TEXT_TO_PAGE_DESCRIPTION_TOKENIZER_ASSERT_SVH

// Condition holds at every edge outside reset.
`define TPTK_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TPTK_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TPTK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/tptk_pkg.sv
// Shared types and constants of the text to page-description tokenizer.
// No dependencies; imported by every tokenizer module.
package tptk_pkg;

  // Token list per input byte and the queue between front and back.
  localparam int TokMax = 6;
  localparam int CntW   = $clog2(TokMax + 1);
  localparam int IdxW   = $clog2(TokMax);
  localparam int CandN  = 7;
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QLvlW  = $clog2(QDepth + 1);

  // Configuration port.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] RegPageLength  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegLiteralMode = 1'd1;
  localparam logic [7:0] PageLengthReset = 8'd66;

  // Stream widths.
  localparam int InDataW  = 8;
  localparam int OutDataW = 16;
  localparam int OutUserW = 4;

  // Character codes.
  localparam logic [7:0] ChCtl    = 8'o031;
  localparam logic [7:0] ChResume = 8'o001;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLpar   = 8'h28;
  localparam logic [7:0] ChRpar   = 8'h29;
  localparam logic [7:0] ChPrintLo = 8'h20;
  localparam logic [7:0] ChPrintHi = 8'h7E;
  localparam logic [3:0] TabStop  = 4'd8;
  localparam logic [15:0] PageMax = 16'hFFFF;

  typedef enum logic [3:0] {
    K_DOC     = 4'd0,
    K_PAGE    = 4'd1,
    K_SHOW    = 4'd2,
    K_NL      = 4'd3,
    K_SHOWCR  = 4'd4,
    K_ENDPAGE = 4'd5,
    K_BS      = 4'd6,
    K_TAB     = 4'd7,
    K_OPEN    = 4'd8,
    K_CHAR    = 4'd9,
    K_OCTAL   = 4'd10,
    K_REPL    = 4'd11,
    K_TRAILER = 4'd12,
    K_SUSPEND = 4'd13
  } tok_kind_t;

  // Input byte classes.
  typedef enum logic [3:0] {
    CLS_EOI,
    CLS_NL,
    CLS_CR,
    CLS_FF,
    CLS_BS,
    CLS_TAB,
    CLS_CTL,
    CLS_SUSP,
    CLS_TEXT
  } byte_class_t;

  // One token: operand and kind.
  typedef struct packed {
    logic [15:0] operand;
    tok_kind_t   kind;
  } tok_t;

  // All tokens caused by one input byte.
  typedef struct packed {
    tok_t [TokMax-1:0] tok;
    logic [CntW-1:0]   count;
  } entry_t;

endpackage

### src/tptk_front.sv
// Front end: accepts input bytes, classifies them, updates job state
// and builds the token list for each byte. Uses tptk_pkg.
module tptk_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tptk_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [tptk_pkg::CfgDataW-1:0]    cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_byte,
  input  logic                             in_eoi,
  input  logic                             q_full,
  output logic                             q_push,
  output tptk_pkg::entry_t                 q_entry
);
  import tptk_pkg::*;

  // Configuration registers
  logic [7:0] page_length;
  logic       literal_mode;

  // Job state
  logic        in_page, in_page_next;
  logic        string_open, string_open_next;
  logic        control_pending, control_pending_next;
  logic [7:0]  line_in_page, line_in_page_next;
  logic [2:0]  column_phase, column_phase_next;
  logic [15:0] pages_started, pages_started_next;

  byte_class_t      cls;
  logic             accept;
  logic             start;
  logic             pend31;
  logic [2:0]       col1;
  logic [15:0]      pages_inc;
  logic [8:0]       line_inc;
  logic             line_end;
  logic             escape;
  logic             printable;
  tok_kind_t        unp_kind;
  tok_t [CandN-1:0] cand;
  logic [CandN-1:0] cand_en;
  logic [CntW-1:0]  pos [CandN];
  logic [CntW-1:0]  total;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      page_length  <= PageLengthReset;
      literal_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegPageLength:  page_length  <= cfg_data;
        RegLiteralMode: literal_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Byte classification
  always_comb begin
    if (in_eoi) begin
      cls = CLS_EOI;
    end else begin
      case (in_byte)
        ChNl:     cls = CLS_NL;
        ChCr:     cls = CLS_CR;
        ChFf:     cls = CLS_FF;
        ChBs:     cls = CLS_BS;
        ChTab:    cls = CLS_TAB;
        ChCtl:    cls = CLS_CTL;
        ChResume: cls = control_pending ? CLS_SUSP : CLS_TEXT;
        default:  cls = CLS_TEXT;
      endcase
    end
  end

  // Shared terms
  assign start     = !in_eoi && !in_page && (in_byte != ChCtl) && (in_byte != ChResume);
  assign pages_inc = pages_started + 16'(pages_started != PageMax);
  assign pend31    = !in_eoi && control_pending && (in_byte != ChResume);
  assign col1      = pend31 ? column_phase + 3'd1 : column_phase;
  assign line_inc  = {1'b0, line_in_page} + 9'd1;
  assign line_end  = line_inc >= {1'b0, page_length};
  assign escape    = (in_byte == ChResume) || (in_byte == ChBslash) ||
                     (in_byte == ChLpar) || (in_byte == ChRpar);
  assign printable = (in_byte >= ChPrintLo) && (in_byte <= ChPrintHi);
  assign unp_kind  = literal_mode ? K_OCTAL : K_REPL;

  // Candidate tokens in emission order, and next job state
  always_comb begin
    cand    = '0;
    cand_en = '0;
    in_page_next         = in_page;
    string_open_next     = string_open;
    control_pending_next = !in_eoi && (in_byte == ChCtl);
    line_in_page_next    = line_in_page;
    column_phase_next    = col1;
    pages_started_next   = pages_started;

    // document and page start
    cand_en[0] = start && (pages_started == '0);
    cand[0]    = '{operand: 16'd0, kind: K_DOC};
    cand_en[1] = start;
    cand[1]    = '{operand: pages_inc, kind: K_PAGE};
    if (start) begin
      in_page_next       = 1'b1;
      pages_started_next = pages_inc;
    end

    // pending 031 not followed by 001
    cand_en[2] = pend31;
    cand[2]    = '{operand: 16'(ChCtl), kind: unp_kind};

    case (cls)
      CLS_EOI, CLS_SUSP: begin
        cand_en[3] = string_open;
        cand[3]    = '{operand: 16'd0, kind: K_SHOW};
        cand_en[4] = in_page;
        cand[4]    = '{operand: 16'd0, kind: K_ENDPAGE};
        cand_en[5] = pages_started != '0;
        cand[5]    = '{operand: pages_started, kind: K_TRAILER};
        cand_en[6] = cls == CLS_SUSP;
        cand[6]    = '{operand: 16'd0, kind: K_SUSPEND};
        in_page_next         = 1'b0;
        string_open_next     = 1'b0;
        control_pending_next = 1'b0;
        line_in_page_next    = '0;
        column_phase_next    = '0;
        pages_started_next   = '0;
      end
      CLS_NL: begin
        cand_en[3] = string_open;
        cand[3]    = '{operand: 16'd0, kind: K_SHOW};
        cand_en[4] = 1'b1;
        cand[4]    = '{operand: 16'd0, kind: K_NL};
        cand_en[5] = line_end;
        cand[5]    = '{operand: 16'd0, kind: K_ENDPAGE};
        string_open_next  = 1'b0;
        column_phase_next = '0;
        if (line_end) begin
          in_page_next      = 1'b0;
          line_in_page_next = '0;
        end else begin
          line_in_page_next = line_inc[7:0];
        end
      end
      CLS_CR: begin
        cand_en[3] = string_open;
        cand[3]    = '{operand: 16'd0, kind: K_SHOWCR};
        string_open_next  = 1'b0;
        column_phase_next = '0;
      end
      CLS_FF: begin
        cand_en[3] = string_open;
        cand[3]    = '{operand: 16'd0, kind: K_SHOW};
        cand_en[4] = 1'b1;
        cand[4]    = '{operand: 16'd0, kind: K_ENDPAGE};
        string_open_next  = 1'b0;
        in_page_next      = 1'b0;
        line_in_page_next = '0;
        column_phase_next = '0;
      end
      CLS_BS: begin
        cand_en[3] = string_open;
        cand[3]    = '{operand: 16'd0, kind: K_SHOW};
        cand_en[4] = 1'b1;
        cand[4]    = '{operand: 16'd0, kind: K_BS};
        string_open_next  = 1'b0;
        column_phase_next = (col1 != '0) ? col1 - 3'd1 : '0;
      end
      CLS_TAB: begin
        cand_en[3] = string_open;
        cand[3]    = '{operand: 16'd0, kind: K_SHOW};
        cand_en[4] = 1'b1;
        cand[4]    = '{operand: 16'(TabStop - {1'b0, col1}), kind: K_TAB};
        string_open_next  = 1'b0;
        column_phase_next = '0;
      end
      CLS_CTL: begin
        // only arms the pending flag
      end
      CLS_TEXT: begin
        cand_en[3] = !string_open;
        cand[3]    = '{operand: 16'd0, kind: K_OPEN};
        cand_en[4] = escape;
        cand[4]    = '{operand: 16'(ChBslash), kind: K_CHAR};
        cand_en[5] = 1'b1;
        cand[5]    = '{operand: 16'(in_byte), kind: printable ? K_CHAR : unp_kind};
        string_open_next  = 1'b1;
        column_phase_next = col1 + 3'd1;
      end
      default: ;
    endcase
  end

  // Pack enabled candidates into consecutive slots
  always_comb begin
    logic [CntW-1:0] run;
    run = '0;
    for (int i = 0; i < CandN; i++) begin
      pos[i] = run;
      run    = run + CntW'(cand_en[i]);
    end
    total = run;
  end

  always_comb begin
    q_entry.tok = '0;
    for (int j = 0; j < TokMax; j++) begin
      for (int i = 0; i < CandN; i++) begin
        if (cand_en[i] && (pos[i] == CntW'(j))) begin
          q_entry.tok[j] = cand[i];
        end
      end
    end
    q_entry.count = (total > CntW'(TokMax)) ? CntW'(TokMax) : total;
  end

  assign q_push = accept && (total != '0);

  // Job state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_page         <= 1'b0;
      string_open     <= 1'b0;
      control_pending <= 1'b0;
      line_in_page    <= '0;
      column_phase    <= '0;
      pages_started   <= '0;
    end else if (accept) begin
      in_page         <= in_page_next;
      string_open     <= string_open_next;
      control_pending <= control_pending_next;
      line_in_page    <= line_in_page_next;
      column_phase    <= column_phase_next;
      pages_started   <= pages_started_next;
    end
  end

endmodule

### src/tptk_queue.sv
// Short queue of token lists between front and back end.
// Uses tptk_pkg and the shared assertion macros.
`include "text_to_page_description_tokenizer_assert.svh"
module tptk_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tptk_pkg::entry_t  push_entry,
  output logic              full,
  input  logic              pop,
  output tptk_pkg::entry_t  head,
  output logic              empty
);
  import tptk_pkg::*;

  localparam logic [QLvlW-1:0] LevelMax = QLvlW'(QDepth);
  localparam logic [QPtrW-1:0] PtrLast  = QPtrW'(QDepth - 1);

  entry_t           slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QLvlW-1:0] level;

  assign full  = level == LevelMax;
  assign empty = level == '0;
  assign head  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + QPtrW'(1);
      end
      level <= level + QLvlW'(push) - QLvlW'(pop);
    end
  end

  `TPTK_ASSERT_IMPLIES(a_no_push_full, push, !full, "push into full token queue")
  `TPTK_ASSERT_IMPLIES(a_push_count, push, push_entry.count != '0, "empty token list queued")
  `TPTK_ASSERT_IMPLIES(a_ptr_match, empty || full, wr_ptr == rd_ptr, "queue pointers out of step")

endmodule

### src/tptk_back.sv
// Back end: walks each queued token list into the output register, one
// token per cycle unless the output stalls. Uses tptk_pkg and the shared assertion macros.
`include "text_to_page_description_tokenizer_assert.svh"
module tptk_back (
  input  logic              clk,
  input  logic              rst,
  input  tptk_pkg::entry_t  q_head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output tptk_pkg::tok_t    out_tok,
  output logic              out_last
);
  import tptk_pkg::*;

  entry_t          cur;
  logic            cur_valid, cur_valid_next;
  logic [IdxW-1:0] idx, idx_next;
  logic            out_load;
  logic            take;
  logic            cur_last;
  logic            cur_done;

  // Output register free, current list position
  assign out_load = !out_valid || out_ready;
  assign take     = out_load && cur_valid;
  assign cur_last = CntW'(idx) == cur.count - CntW'(1);
  assign cur_done = take && cur_last;
  assign q_pop    = !q_empty && (!cur_valid || cur_done);

  always_comb begin
    cur_valid_next = cur_valid;
    idx_next       = idx;
    if (q_pop) begin
      cur_valid_next = 1'b1;
      idx_next       = '0;
    end else if (cur_done) begin
      cur_valid_next = 1'b0;
    end else if (take) begin
      idx_next = idx + IdxW'(1);
    end
  end

  // Current list
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      cur_valid <= cur_valid_next;
      idx       <= idx_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_tok  <= cur.tok[idx];
      out_last <= cur_last;
    end
  end

  `TPTK_ASSERT_IMPLIES(a_idx_range, cur_valid, CntW'(idx) < cur.count, "token index past list")
  `TPTK_ASSERT_NEXT(a_drain, cur_done && q_empty, !cur_valid, "list kept after last token")
  `TPTK_ASSERT_NEXT(a_idx_hold, cur_valid && !out_load, $stable(idx), "index moved while stalled")

endmodule

### src/text_to_page_description_tokenizer.sv
// Top level of the text to page-description tokenizer.
// Depends on tptk_pkg, tptk_front, tptk_queue and tptk_back.
//
// Input stream: one text byte per request on s_tdata; s_tlast set means end
// of input, which flushes the open string and page and emits the trailer if
// a page was started. Output stream: one token per request; m_tuser carries
// the token kind, m_tdata the operand, and m_tlast marks the final token
// that one input byte caused. Bytes that cause no token produce no request.
// Config: cfg_we writes page_length (index 0) or literal_mode (index 1);
// write only while the block is idle.
// Path: the first token of a byte passes the token queue, the current list
// register and the output token register before it shows on m_tvalid.
// Throughput: one byte per cycle at the input while the token queue has
// room; the output moves one token per cycle while m_tready is high, and a
// byte yields one to six tokens. The single output token register sets that rate.
// Reset (rst, synchronous): page_length 66, literal_mode 0, no job open,
// queue and output empty. When the receiver stalls, the output holds, the
// back end holds its list, the two-entry queue fills and s_tready drops.
module text_to_page_description_tokenizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tptk_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [tptk_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tptk_pkg::InDataW-1:0]      s_tdata,   // [7:0] data_byte
  input  logic                              s_tlast,   // end_of_input
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tptk_pkg::OutDataW-1:0]     m_tdata,   // [15:0] operand
  output logic [tptk_pkg::OutUserW-1:0]     m_tuser,   // [3:0] token_kind
  output logic                              m_tlast    // last_token
);
  import tptk_pkg::*;

  entry_t q_in;
  entry_t q_head;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;
  tok_t   out_tok;

  tptk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_eoi    (s_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  tptk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  tptk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tok   (out_tok),
    .out_last  (m_tlast)
  );

  // Split the token into kind and operand
  assign m_tdata = out_tok.operand;
  assign m_tuser = out_tok.kind;

endmodule
